### sv/hbmo_pkg.sv
// shared types, constants and the popcount function of the best match unit
package hbmo_pkg;

  localparam int DescWords = 4;
  localparam int WordBits = 64;
  localparam int LevelBits = 3;
  localparam int IndexBits = 10;
  localparam int DistBits = 9;
  localparam int CountBits = 7;

  localparam logic [DistBits-1:0] NoDist = 9'd256;
  localparam logic [DistBits-1:0] ThresholdReset = 9'd50;
  localparam logic [LevelBits-1:0] SlackReset = 3'd1;

  localparam logic OpQuery = 1'b0;
  localparam logic OpCandidate = 1'b1;

  localparam logic RegMatchThreshold = 1'b0;
  localparam logic RegLevelSlack = 1'b1;

  typedef struct packed {
    logic is_query;
    logic in_window;
    logic last;
    logic [IndexBits-1:0] idx;
    logic [DescWords-1:0][CountBits-1:0] cnt;
  } mid_word_t;

  typedef struct packed {
    logic matched;
    logic any_in_window;
    logic [IndexBits-1:0] best_index;
    logic [DistBits-1:0] best_distance;
  } res_word_t;

  function automatic logic [CountBits-1:0] pop64(input logic [WordBits-1:0] v);
    logic [WordBits-1:0] a;
    logic [WordBits-1:0] b;
    logic [WordBits-1:0] c;
    logic [CountBits-1:0] s01;
    logic [CountBits-1:0] s23;
    logic [CountBits-1:0] s45;
    logic [CountBits-1:0] s67;
    a = v - ((v >> 1) & 64'h5555_5555_5555_5555);
    b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
    c = (b + (b >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    s01 = CountBits'(c[7:0]) + CountBits'(c[15:8]);
    s23 = CountBits'(c[23:16]) + CountBits'(c[31:24]);
    s45 = CountBits'(c[39:32]) + CountBits'(c[47:40]);
    s67 = CountBits'(c[55:48]) + CountBits'(c[63:56]);
    return (s01 + s23) + (s45 + s67);
  endfunction

endpackage

### sv/hbmo_fifo.sv
// small first-in first-out queue with registered storage
module hbmo_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign dout = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/hbmo_front.sv
// front end: holds the query, classifies each word and counts differing bits
module hbmo_front (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          push,
  output logic                                          full,
  input  logic                                          op,
  input  logic [hbmo_pkg::WordBits-1:0]                 desc_word0,
  input  logic [hbmo_pkg::WordBits-1:0]                 desc_word1,
  input  logic [hbmo_pkg::WordBits-1:0]                 desc_word2,
  input  logic [hbmo_pkg::WordBits-1:0]                 desc_word3,
  input  logic [hbmo_pkg::LevelBits-1:0]                scale_level,
  input  logic [hbmo_pkg::IndexBits-1:0]                cand_index,
  input  logic                                          last,
  input  logic [hbmo_pkg::LevelBits-1:0]                level_slack,
  output logic                                          mid_push,
  input  logic                                          mid_full,
  output hbmo_pkg::mid_word_t                           mid_word
);

  import hbmo_pkg::*;

  logic [DescWords-1:0][WordBits-1:0] query_desc;
  logic [LevelBits-1:0] query_level;

  logic s1_valid;
  logic s1_is_query;
  logic s1_in_window;
  logic s1_last;
  logic [IndexBits-1:0] s1_idx;
  logic [DescWords-1:0][WordBits-1:0] s1_xor;

  logic accept;
  logic [DescWords-1:0][WordBits-1:0] in_desc;
  logic [LevelBits-1:0] level_diff;

  assign in_desc = {desc_word3, desc_word2, desc_word1, desc_word0};
  assign full = s1_valid && mid_full;
  assign accept = push && !full;
  assign level_diff = (scale_level > query_level) ? scale_level - query_level
                                                  : query_level - scale_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_desc <= '0;
      query_level <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (!mid_full) begin
        s1_valid <= 1'b0;
      end
      if (accept && op == OpQuery) begin
        query_desc <= in_desc;
        query_level <= scale_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_is_query <= (op == OpQuery);
      s1_in_window <= (level_diff <= level_slack);
      s1_last <= last;
      s1_idx <= cand_index;
      s1_xor <= query_desc ^ in_desc;
    end
  end

  always_comb begin
    mid_word.is_query = s1_is_query;
    mid_word.in_window = s1_in_window;
    mid_word.last = s1_last;
    mid_word.idx = s1_idx;
    for (int i = 0; i < DescWords; i++) begin
      mid_word.cnt[i] = pop64(s1_xor[i]);
    end
  end

  assign mid_push = s1_valid;

endmodule

### sv/hbmo_back.sv
// back end: running minimum over candidates and result forming
module hbmo_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           mid_empty,
  output logic                           mid_pop,
  input  hbmo_pkg::mid_word_t            mid_word,
  input  logic                           res_full,
  output logic                           res_push,
  output hbmo_pkg::res_word_t            res_word,
  input  logic [hbmo_pkg::DistBits-1:0]  match_threshold
);

  import hbmo_pkg::*;

  logic [DistBits-1:0] best_dist;
  logic [IndexBits-1:0] best_idx;
  logic seen_any;

  logic [DistBits-1:0] cand_dist;
  logic take;
  logic [DistBits-1:0] best_dist_next;
  logic [IndexBits-1:0] best_idx_next;
  logic seen_any_next;

  assign cand_dist = (DistBits'(mid_word.cnt[0]) + DistBits'(mid_word.cnt[1]))
                   + (DistBits'(mid_word.cnt[2]) + DistBits'(mid_word.cnt[3]));

  assign mid_pop = !mid_empty && !(mid_word.last && res_full);
  assign res_push = mid_pop && mid_word.last;

  always_comb begin
    take = !mid_word.is_query && mid_word.in_window && (!seen_any || cand_dist < best_dist);
    if (mid_word.is_query) begin
      best_dist_next = NoDist;
      best_idx_next = '0;
      seen_any_next = 1'b0;
    end else begin
      best_dist_next = take ? cand_dist : best_dist;
      best_idx_next = take ? mid_word.idx : best_idx;
      seen_any_next = seen_any || mid_word.in_window;
    end
    res_word.matched = seen_any_next && (best_dist_next <= match_threshold);
    res_word.any_in_window = seen_any_next;
    res_word.best_index = best_idx_next;
    res_word.best_distance = best_dist_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_dist <= NoDist;
      best_idx <= '0;
      seen_any <= 1'b0;
    end else if (mid_pop) begin
      if (mid_word.last) begin
        best_dist <= NoDist;
        best_idx <= '0;
        seen_any <= 1'b0;
      end else begin
        best_dist <= best_dist_next;
        best_idx <= best_idx_next;
        seen_any <= seen_any_next;
      end
    end
  end

endmodule

### sv/hamming_best_match_octave_unit.sv
// top level of the nearest binary descriptor match unit
//
//  channel   handshake            fields
//  input     push / full          op, desc_word0..3, scale_level, cand_index, last
//  result    empty / pop          matched, any_in_window, best_index, best_distance
//  config    cfg_we               cfg_index, cfg_data
//
// one word is taken every cycle while full is low; the 256-bit popcount and the
// running minimum compare each take one stage, so a result passes the front
// register, the middle queue and the result queue after its last word is taken.
// stalls on the result side fill a four-word queue between front and back before
// full rises. reset is synchronous.
module hamming_best_match_octave_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 op,
  input  logic [hbmo_pkg::WordBits-1:0]        desc_word0,
  input  logic [hbmo_pkg::WordBits-1:0]        desc_word1,
  input  logic [hbmo_pkg::WordBits-1:0]        desc_word2,
  input  logic [hbmo_pkg::WordBits-1:0]        desc_word3,
  input  logic [hbmo_pkg::LevelBits-1:0]       scale_level,
  input  logic [hbmo_pkg::IndexBits-1:0]       cand_index,
  input  logic                                 last,
  output logic                                 empty,
  input  logic                                 pop,
  output logic                                 matched,
  output logic                                 any_in_window,
  output logic [hbmo_pkg::IndexBits-1:0]       best_index,
  output logic [hbmo_pkg::DistBits-1:0]        best_distance,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [hbmo_pkg::DistBits-1:0]        cfg_data
);

  import hbmo_pkg::*;

  logic [DistBits-1:0] match_threshold;
  logic [LevelBits-1:0] level_slack;

  logic mid_push;
  logic mid_full;
  logic mid_empty;
  logic mid_pop;
  mid_word_t mid_in;
  mid_word_t mid_out;

  logic res_push;
  logic res_full;
  res_word_t res_in;
  res_word_t res_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_threshold <= ThresholdReset;
      level_slack <= SlackReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegMatchThreshold: match_threshold <= cfg_data;
        RegLevelSlack: level_slack <= cfg_data[LevelBits-1:0];
        default: ;
      endcase
    end
  end

  hbmo_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .op          (op),
    .desc_word0  (desc_word0),
    .desc_word1  (desc_word1),
    .desc_word2  (desc_word2),
    .desc_word3  (desc_word3),
    .scale_level (scale_level),
    .cand_index  (cand_index),
    .last        (last),
    .level_slack (level_slack),
    .mid_push    (mid_push),
    .mid_full    (mid_full),
    .mid_word    (mid_in)
  );

  hbmo_fifo #(
    .WIDTH ($bits(mid_word_t)),
    .DEPTH (4)
  ) u_mid_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .full  (mid_full),
    .din   (mid_in),
    .pop   (mid_pop),
    .empty (mid_empty),
    .dout  (mid_out)
  );

  hbmo_back u_back (
    .clk             (clk),
    .rst             (rst),
    .mid_empty       (mid_empty),
    .mid_pop         (mid_pop),
    .mid_word        (mid_out),
    .res_full        (res_full),
    .res_push        (res_push),
    .res_word        (res_in),
    .match_threshold (match_threshold)
  );

  hbmo_fifo #(
    .WIDTH ($bits(res_word_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .din   (res_in),
    .pop   (pop),
    .empty (empty),
    .dout  (res_out)
  );

  assign matched = res_out.matched;
  assign any_in_window = res_out.any_in_window;
  assign best_index = res_out.best_index;
  assign best_distance = res_out.best_distance;

endmodule

### tb/hbmo_match_checker.sv
// watches the channels of the best match unit, predicts each result word and compares
module hbmo_match_checker
  import hbmo_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 full,
  input  logic                 op,
  input  logic [WordBits-1:0]  desc_word0,
  input  logic [WordBits-1:0]  desc_word1,
  input  logic [WordBits-1:0]  desc_word2,
  input  logic [WordBits-1:0]  desc_word3,
  input  logic [LevelBits-1:0] scale_level,
  input  logic [IndexBits-1:0] cand_index,
  input  logic                 last,
  input  logic                 empty,
  input  logic                 pop,
  input  logic                 matched,
  input  logic                 any_in_window,
  input  logic [IndexBits-1:0] best_index,
  input  logic [DistBits-1:0]  best_distance,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [DistBits-1:0]  cfg_data,
  output int                   fail_count,
  output int                   waiting
);

  res_word_t best_match_q[$];

  logic [DescWords-1:0][WordBits-1:0] query_bits;
  logic [LevelBits-1:0]               query_lvl;
  logic [DistBits-1:0]                run_dist;
  logic [IndexBits-1:0]               run_idx;
  logic                               run_seen;
  logic [DistBits-1:0]                thr;
  logic [LevelBits-1:0]               slack;
  int                                 fails = 0;

  always @(posedge clk) begin : watch
    logic [DescWords-1:0][WordBits-1:0] cand_bits;
    logic [LevelBits-1:0]               lvl_gap;
    logic [DistBits-1:0]                cand_dist;
    res_word_t                          got;
    res_word_t                          want;
    if (rst) begin
      query_bits = '0;
      query_lvl = '0;
      run_dist = NoDist;
      run_idx = '0;
      run_seen = 1'b0;
      thr = 9'd50;
      slack = 3'd1;
      best_match_q.delete();
    end else begin
      if (pop && !empty) begin
        got.matched = matched;
        got.any_in_window = any_in_window;
        got.best_index = best_index;
        got.best_distance = best_distance;
        if (best_match_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: unexpected word m=%0b a=%0b idx=%0d dist=%0d",
                     got.matched, got.any_in_window, got.best_index, got.best_distance);
        end else begin
          want = best_match_q.pop_front();
          if (got.matched !== want.matched || got.any_in_window !== want.any_in_window ||
              got.best_index !== want.best_index ||
              got.best_distance !== want.best_distance) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected m=%0b a=%0b idx=%0d dist=%0d",
                       want.matched, want.any_in_window, want.best_index,
                       want.best_distance,
                       ", got m=%0b a=%0b idx=%0d dist=%0d",
                       got.matched, got.any_in_window, got.best_index,
                       got.best_distance);
          end
        end
      end
      if (push && !full) begin
        cand_bits = {desc_word3, desc_word2, desc_word1, desc_word0};
        if (op == OpQuery) begin
          query_bits = cand_bits;
          query_lvl = scale_level;
          run_dist = NoDist;
          run_idx = '0;
          run_seen = 1'b0;
          if (last) begin
            want.matched = 1'b0;
            want.any_in_window = 1'b0;
            want.best_index = '0;
            want.best_distance = NoDist;
            best_match_q = {best_match_q, want};
          end
        end else begin
          lvl_gap = (scale_level > query_lvl) ? scale_level - query_lvl
                                              : query_lvl - scale_level;
          if (lvl_gap <= slack) begin
            cand_dist = DistBits'($countones(query_bits ^ cand_bits));
            if (!run_seen || cand_dist < run_dist) begin
              run_dist = cand_dist;
              run_idx = cand_index;
            end
            run_seen = 1'b1;
          end
          if (last) begin
            want.matched = run_seen && (run_dist <= thr);
            want.any_in_window = run_seen;
            want.best_index = run_idx;
            want.best_distance = run_dist;
            best_match_q = {best_match_q, want};
            run_dist = NoDist;
            run_idx = '0;
            run_seen = 1'b0;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == RegMatchThreshold)
          thr = cfg_data;
        else
          slack = cfg_data[LevelBits-1:0];
      end
    end
    fail_count <= fails;
    waiting <= best_match_q.size();
  end

endmodule

### tb/tb_hamming_best_match_octave_unit.sv
// stimulus and verdict for the best match unit, with the checker beside it
module tb_hamming_best_match_octave_unit;
  import hbmo_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 119;

  typedef struct packed {
    logic                               op;
    logic [DescWords-1:0][WordBits-1:0] desc;
    logic [LevelBits-1:0]               lvl;
    logic [IndexBits-1:0]               idx;
    logic                               last;
  } probe_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic                 op = 1'b0;
  logic [WordBits-1:0]  desc_word0 = '0;
  logic [WordBits-1:0]  desc_word1 = '0;
  logic [WordBits-1:0]  desc_word2 = '0;
  logic [WordBits-1:0]  desc_word3 = '0;
  logic [LevelBits-1:0] scale_level = '0;
  logic [IndexBits-1:0] cand_index = '0;
  logic                 last = 1'b0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic                 matched;
  logic                 any_in_window;
  logic [IndexBits-1:0] best_index;
  logic [DistBits-1:0]  best_distance;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = 1'b0;
  logic [DistBits-1:0]  cfg_data = '0;
  int                   fail_count;
  int                   waiting;

  int     gap_top = 11;
  int     cycles = 0;
  probe_t held_q = '0;

  hamming_best_match_octave_unit DUT (.*);

  hbmo_match_checker u_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAIL hamming_best_match_octave_unit");
      $finish;
    end
  end

  function automatic probe_t pack_word(logic o, logic [255:0] d, logic [LevelBits-1:0] l,
                                       logic [IndexBits-1:0] i, logic e);
    probe_t w;
    w.op = o;
    w.desc = d;
    w.lvl = l;
    w.idx = i;
    w.last = e;
    return w;
  endfunction

  function automatic logic [255:0] rand_desc();
    logic [255:0] v;
    for (int i = 0; i < 8; i++)
      v[i*32 +: 32] = $urandom;
    return v;
  endfunction

  function automatic logic [255:0] flip_bits(logic [255:0] base, int n);
    logic [255:0] v;
    v = base;
    for (int i = 0; i < n; i++)
      v[$urandom_range(0, 255)] ^= 1'b1;
    return v;
  endfunction

  task automatic send(input probe_t w);
    int gap;
    gap = $urandom_range(0, gap_top);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    op <= w.op;
    desc_word0 <= w.desc[0];
    desc_word1 <= w.desc[1];
    desc_word2 <= w.desc[2];
    desc_word3 <= w.desc[3];
    scale_level <= w.lvl;
    cand_index <= w.idx;
    last <= w.last;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic i, input logic [DistBits-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= i;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    int     sent;
    int     k;
    int     r;
    int     lv;
    probe_t c;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 88) begin
        if (r < 78) begin
          held_q = pack_word(OpQuery, rand_desc(), LevelBits'($urandom_range(0, 7)),
                             IndexBits'($urandom_range(0, 1023)),
                             $urandom_range(0, 19) == 0);
          send(held_q);
          sent++;
        end
        if (r >= 78 || !held_q.last) begin
          k = $urandom_range(1, 6);
          for (int j = 0; j < k; j++) begin
            case ($urandom_range(0, 9))
              0: c.desc = rand_desc();
              1: c.desc = held_q.desc;
              default: c.desc = flip_bits(held_q.desc, $urandom_range(0, 80));
            endcase
            if ($urandom_range(0, 3) == 0) begin
              lv = $urandom_range(0, 7);
            end else begin
              lv = int'(held_q.lvl) + int'($urandom_range(0, 4)) - 2;
              if (lv < 0) lv = 0;
              if (lv > 7) lv = 7;
            end
            c.op = OpCandidate;
            c.lvl = lv[LevelBits-1:0];
            c.idx = IndexBits'($urandom_range(0, 1023));
            c.last = (j == k - 1);
            send(c);
            sent++;
          end
        end
      end else begin
        send(pack_word(1'($urandom_range(0, 1)), rand_desc(),
                       LevelBits'($urandom_range(0, 7)),
                       IndexBits'($urandom_range(0, 1023)), 1'($urandom_range(0, 1))));
        sent++;
      end
    end
  endtask

  initial begin : pop_side
    int gap;
    wait (!rst);
    forever begin
      gap = $urandom_range(0, gap_top);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  initial begin : push_side
    logic [255:0] m50;
    logic [255:0] m51;
    m50 = {206'b0, {50{1'b1}}};
    m51 = {205'b0, {51{1'b1}}};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // candidates against the reset query, nearer one later
    send(pack_word(OpCandidate, 256'h7, 3'd1, 10'd7, 1'b0));
    send(pack_word(OpCandidate, '0, 3'd0, 10'd5, 1'b1));
    // query with no candidates
    send(pack_word(OpQuery, '1, 3'd3, 10'd0, 1'b1));
    // exact match, tie kept by the earlier one, out of window skipped
    send(pack_word(OpQuery, '1, 3'd7, 10'd0, 1'b0));
    send(pack_word(OpCandidate, '1, 3'd7, 10'd1023, 1'b0));
    send(pack_word(OpCandidate, '1, 3'd6, 10'd1, 1'b0));
    send(pack_word(OpCandidate, '0, 3'd5, 10'd3, 1'b0));
    send(pack_word(OpCandidate, flip_bits('1, 1), 3'd7, 10'd2, 1'b1));
    // fresh search against the kept query, first one at full distance
    send(pack_word(OpCandidate, '0, 3'd6, 10'd9, 1'b1));
    // threshold boundary
    send(pack_word(OpQuery, '0, 3'd0, 10'd1023, 1'b0));
    send(pack_word(OpCandidate, m50, 3'd1, 10'd100, 1'b1));
    send(pack_word(OpCandidate, m51, 3'd0, 10'd200, 1'b1));
    send(pack_word(OpCandidate, '0, 3'd2, 10'd300, 1'b1));
    send(pack_word(OpQuery, {64{4'h5}}, 3'd4, 10'd0, 1'b0));
    send(pack_word(OpCandidate, {64{4'hA}}, 3'd4, 10'd512, 1'b1));
    // a new query drops an open search
    send(pack_word(OpQuery, {64{4'hA}}, 3'd4, 10'd0, 1'b0));
    send(pack_word(OpCandidate, {64{4'hA}}, 3'd4, 10'd11, 1'b0));
    send(pack_word(OpQuery, rand_desc(), 3'd2, 10'd0, 1'b1));
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin write_reg(RegMatchThreshold, 9'd0);   write_reg(RegLevelSlack, 9'd0); end
        1: begin write_reg(RegMatchThreshold, 9'd256); write_reg(RegLevelSlack, 9'd7); end
        2: begin write_reg(RegMatchThreshold, 9'd511); write_reg(RegLevelSlack, 9'd3); end
        3: begin write_reg(RegMatchThreshold, 9'd50);  write_reg(RegLevelSlack, 9'd1); end
        default: begin
          write_reg(RegMatchThreshold, DistBits'($urandom_range(0, 300)));
          write_reg(RegLevelSlack, DistBits'($urandom_range(0, 7)));
        end
      endcase
      gap_top = (p == 3 || p == 6) ? 0 : ((p == 5) ? 2 : 11);
      random_phase(PhaseItems);
      settle();
    end

    if (fail_count == 0 && waiting == 0)
      $display("PASS hamming_best_match_octave_unit");
    else
      $display("FAIL hamming_best_match_octave_unit");
    $finish;
  end

endmodule

### filelist.f
sv/hbmo_pkg.sv
sv/hbmo_fifo.sv
sv/hbmo_front.sv
sv/hbmo_back.sv
sv/hamming_best_match_octave_unit.sv
tb/hbmo_match_checker.sv
tb/tb_hamming_best_match_octave_unit.sv
